@@ rtl/core/vfc_pkg.sv @@
`default_nettype none
package vfc_pkg;

  localparam int COORD_BITS = 5;
  localparam int POS_BITS   = 6;
  localparam int VALUE_BITS = 8;
  localparam int SIDE_BITS  = 3;
  localparam int CMD_BITS   = 2;
  localparam int OUT_ID_BITS = 8;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 32;

  localparam logic [CMD_BITS-1:0] CMD_LOAD_VOXEL    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_NEIGHBOR = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_MESH          = 2'd2;

  localparam logic [SIDE_BITS-1:0] FACE_POS_Y = 3'd0;
  localparam logic [SIDE_BITS-1:0] FACE_NEG_Y = 3'd1;
  localparam logic [SIDE_BITS-1:0] FACE_POS_X = 3'd2;
  localparam logic [SIDE_BITS-1:0] FACE_NEG_X = 3'd3;
  localparam logic [SIDE_BITS-1:0] FACE_POS_Z = 3'd4;
  localparam logic [SIDE_BITS-1:0] FACE_NEG_Z = 3'd5;
  localparam logic [SIDE_BITS-1:0] NUM_FACES  = 3'd6;

  localparam logic [2:0] LAST_VERTEX = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ID_RD,
    ST_ID_CHK,
    ST_FACE_RD,
    ST_FACE_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic write_voxel;
    logic write_neighbor;
    logic read_center;
    logic latch_id;
    logic mark_face;
    logic face_clear;
    logic face_next;
    logic vert_clear;
    logic vert_next;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic in_range;
    logic side_ok;
    logic id_zero;
    logic face_last;
    logic exposed;
    logic vert_last;
    logic final_vertex;
    logic out_free;
  } dp_status_t;

  // Corner of the quad used by each of the six vertices of two triangles.
  function automatic logic [1:0] tri_corner(input logic [2:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd0;
      3'd4: c = 2'd2;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Corner offset as {dx, dy, dz}.
  function automatic logic [2:0] corner_offset(input logic [2:0] f, input logic [1:0] c);
    logic [2:0] o;
    unique case ({f, c})
      5'b000_00: o = 3'b011;
      5'b000_01: o = 3'b111;
      5'b000_10: o = 3'b110;
      5'b000_11: o = 3'b010;
      5'b001_00: o = 3'b000;
      5'b001_01: o = 3'b100;
      5'b001_10: o = 3'b101;
      5'b001_11: o = 3'b001;
      5'b010_00: o = 3'b100;
      5'b010_01: o = 3'b110;
      5'b010_10: o = 3'b111;
      5'b010_11: o = 3'b101;
      5'b011_00: o = 3'b001;
      5'b011_01: o = 3'b011;
      5'b011_10: o = 3'b010;
      5'b011_11: o = 3'b000;
      5'b100_00: o = 3'b001;
      5'b100_01: o = 3'b101;
      5'b100_10: o = 3'b111;
      5'b100_11: o = 3'b011;
      5'b101_00: o = 3'b010;
      5'b101_01: o = 3'b110;
      5'b101_10: o = 3'b100;
      5'b101_11: o = 3'b000;
      default:   o = 3'b000;
    endcase
    return o;
  endfunction

  // Texture coordinate as {u, v}.
  function automatic logic [1:0] face_uv(input logic [2:0] f, input logic [1:0] c);
    logic [1:0] uv;
    unique case ({f, c})
      5'b000_00: uv = 2'b00;
      5'b000_01: uv = 2'b10;
      5'b000_10: uv = 2'b11;
      5'b000_11: uv = 2'b01;
      5'b001_00: uv = 2'b01;
      5'b001_01: uv = 2'b11;
      5'b001_10: uv = 2'b10;
      5'b001_11: uv = 2'b00;
      5'b010_00: uv = 2'b01;
      5'b010_01: uv = 2'b00;
      5'b010_10: uv = 2'b10;
      5'b010_11: uv = 2'b11;
      5'b011_00: uv = 2'b01;
      5'b011_01: uv = 2'b00;
      5'b011_10: uv = 2'b10;
      5'b011_11: uv = 2'b11;
      5'b100_00: uv = 2'b01;
      5'b100_01: uv = 2'b11;
      5'b100_10: uv = 2'b10;
      5'b100_11: uv = 2'b00;
      5'b101_00: uv = 2'b00;
      5'b101_01: uv = 2'b10;
      5'b101_10: uv = 2'b11;
      5'b101_11: uv = 2'b01;
      default:   uv = 2'b00;
    endcase
    return uv;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/vfc_ctrl.sv @@
`default_nettype none
module vfc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  vfc_pkg::dp_status_t status,
  output vfc_pkg::dp_cmd_t    cmd
);

  vfc_pkg::state_t state;
  vfc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      vfc_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = vfc_pkg::ST_DECODE;
        end
      end
      vfc_pkg::ST_DECODE: begin
        state_next = vfc_pkg::ST_IDLE;
        if (status.in_range) begin
          unique case (status.cmd)
            vfc_pkg::CMD_LOAD_VOXEL:    cmd.write_voxel = 1'b1;
            vfc_pkg::CMD_LOAD_NEIGHBOR: cmd.write_neighbor = status.side_ok;
            vfc_pkg::CMD_MESH:          state_next = vfc_pkg::ST_ID_RD;
            default:                    state_next = vfc_pkg::ST_IDLE;
          endcase
        end
      end
      vfc_pkg::ST_ID_RD: begin
        cmd.read_center = 1'b1;
        state_next      = vfc_pkg::ST_ID_CHK;
      end
      vfc_pkg::ST_ID_CHK: begin
        if (status.id_zero) begin
          state_next = vfc_pkg::ST_IDLE;
        end else begin
          cmd.latch_id   = 1'b1;
          cmd.face_clear = 1'b1;
          state_next     = vfc_pkg::ST_FACE_RD;
        end
      end
      vfc_pkg::ST_FACE_RD: begin
        state_next = vfc_pkg::ST_FACE_CHK;
      end
      vfc_pkg::ST_FACE_CHK: begin
        cmd.mark_face = 1'b1;
        if (status.face_last) begin
          cmd.face_clear = 1'b1;
          cmd.vert_clear = 1'b1;
          state_next     = vfc_pkg::ST_EMIT;
        end else begin
          cmd.face_next = 1'b1;
          state_next    = vfc_pkg::ST_FACE_RD;
        end
      end
      vfc_pkg::ST_EMIT: begin
        if (!status.exposed) begin
          // A voxel with no exposed face runs off the end here.
          if (status.face_last) begin
            state_next = vfc_pkg::ST_IDLE;
          end else begin
            cmd.face_next = 1'b1;
          end
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.vert_last) begin
            cmd.vert_clear = 1'b1;
            if (status.final_vertex) begin
              state_next = vfc_pkg::ST_IDLE;
            end else begin
              cmd.face_next = 1'b1;
            end
          end else begin
            cmd.vert_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = vfc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/vfc_datapath.sv @@
`default_nettype none
module vfc_datapath #(
  parameter int SIDE    = 32,
  parameter int ID_BITS = 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [vfc_pkg::IN_DATA_BITS-1:0]     s_tdata,
  input  wire  [vfc_pkg::CMD_BITS-1:0]         s_tuser,
  input  vfc_pkg::dp_cmd_t                     cmd,
  output vfc_pkg::dp_status_t                  status,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [vfc_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  output logic [vfc_pkg::SIDE_BITS-1:0]        m_tuser,
  output logic                                 m_tlast
);

  localparam int CW = $clog2(SIDE);
  localparam int VA = 3 * CW;
  localparam int PA = vfc_pkg::SIDE_BITS + 2 * CW;
  localparam logic [6:0]    SIDE_W = 7'(SIDE);
  localparam logic [CW-1:0] CMAX   = CW'(SIDE - 1);

  logic [vfc_pkg::CMD_BITS-1:0]   cap_cmd;
  logic [vfc_pkg::COORD_BITS-1:0] cap_x;
  logic [vfc_pkg::COORD_BITS-1:0] cap_y;
  logic [vfc_pkg::COORD_BITS-1:0] cap_z;
  logic [vfc_pkg::SIDE_BITS-1:0]  cap_side;
  logic [vfc_pkg::VALUE_BITS-1:0] cap_value;

  logic [ID_BITS-1:0] voxel_mem [2**VA];
  logic               plane_mem [2**PA];
  logic [ID_BITS-1:0] vox_rdata;
  logic               plane_rdata;

  logic [ID_BITS-1:0] id_reg;
  logic [5:0]         mask;
  logic [2:0]         face;
  logic [2:0]         vert;

  logic [6:0]    x7, y7, z7;
  logic [CW-1:0] xc, yc, zc;
  logic [CW-1:0] nxc, nyc, nzc;
  logic          in_chunk;
  logic [VA-1:0] center_addr;
  logic [VA-1:0] vox_raddr;
  logic [PA-1:0] plane_waddr;
  logic [PA-1:0] plane_raddr;
  logic [23:0]   val_ext;
  logic [23:0]   id_ext;
  logic          higher_exposed;
  logic [1:0]    corner;
  logic [2:0]    offs;
  logic [1:0]    uv;
  logic [vfc_pkg::POS_BITS-1:0] pos_x, pos_y, pos_z;

  assign x7 = {2'b00, cap_x};
  assign y7 = {2'b00, cap_y};
  assign z7 = {2'b00, cap_z};
  assign xc = x7[CW-1:0];
  assign yc = y7[CW-1:0];
  assign zc = z7[CW-1:0];
  assign center_addr = {yc, zc, xc};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_cmd   <= s_tuser;
      cap_x     <= s_tdata[4:0];
      cap_y     <= s_tdata[9:5];
      cap_z     <= s_tdata[14:10];
      cap_side  <= s_tdata[17:15];
      cap_value <= s_tdata[25:18];
    end
  end

  always_comb begin
    nxc      = xc;
    nyc      = yc;
    nzc      = zc;
    in_chunk = 1'b1;
    unique case (face)
      vfc_pkg::FACE_POS_Y: begin
        nyc      = yc + CW'(1);
        in_chunk = (yc != CMAX);
      end
      vfc_pkg::FACE_NEG_Y: begin
        nyc      = yc - CW'(1);
        in_chunk = (yc != '0);
      end
      vfc_pkg::FACE_POS_X: begin
        nxc      = xc + CW'(1);
        in_chunk = (xc != CMAX);
      end
      vfc_pkg::FACE_NEG_X: begin
        nxc      = xc - CW'(1);
        in_chunk = (xc != '0);
      end
      vfc_pkg::FACE_POS_Z: begin
        nzc      = zc + CW'(1);
        in_chunk = (zc != CMAX);
      end
      vfc_pkg::FACE_NEG_Z: begin
        nzc      = zc - CW'(1);
        in_chunk = (zc != '0);
      end
      default: in_chunk = 1'b1;
    endcase
  end

  assign vox_raddr = cmd.read_center ? center_addr : {nyc, nzc, nxc};

  always_comb begin
    if (cap_side < vfc_pkg::FACE_POS_X) begin
      plane_waddr = {cap_side, xc, zc};
    end else if (cap_side < vfc_pkg::FACE_POS_Z) begin
      plane_waddr = {cap_side, yc, zc};
    end else begin
      plane_waddr = {cap_side, xc, yc};
    end
    if (face < vfc_pkg::FACE_POS_X) begin
      plane_raddr = {face, xc, zc};
    end else if (face < vfc_pkg::FACE_POS_Z) begin
      plane_raddr = {face, yc, zc};
    end else begin
      plane_raddr = {face, xc, yc};
    end
  end

  assign val_ext = {16'h0000, cap_value};

  always_ff @(posedge clk) begin
    if (cmd.write_voxel) begin
      voxel_mem[center_addr] <= val_ext[ID_BITS-1:0];
    end
    vox_rdata <= voxel_mem[vox_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_neighbor) begin
      plane_mem[plane_waddr] <= (cap_value == '0);
    end
    plane_rdata <= plane_mem[plane_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_id) begin
      id_reg <= vox_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face <= '0;
      vert <= '0;
      mask <= '0;
    end else begin
      if (cmd.mark_face) begin
        mask[face] <= in_chunk ? (vox_rdata == '0) : plane_rdata;
      end
      if (cmd.face_clear) begin
        face <= '0;
      end else if (cmd.face_next) begin
        face <= face + 3'd1;
      end
      if (cmd.vert_clear) begin
        vert <= '0;
      end else if (cmd.vert_next) begin
        vert <= vert + 3'd1;
      end
    end
  end

  always_comb begin
    higher_exposed = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if ((3'(i) > face) && mask[i]) begin
        higher_exposed = 1'b1;
      end
    end
  end

  assign status.cmd          = cap_cmd;
  assign status.in_range     = (x7 < SIDE_W) && (y7 < SIDE_W) && (z7 < SIDE_W);
  assign status.side_ok      = (cap_side < vfc_pkg::NUM_FACES);
  assign status.id_zero      = (vox_rdata == '0);
  assign status.face_last    = (face == vfc_pkg::FACE_NEG_Z);
  assign status.exposed      = mask[face];
  assign status.vert_last    = (vert == vfc_pkg::LAST_VERTEX);
  assign status.final_vertex = (vert == vfc_pkg::LAST_VERTEX) && !higher_exposed;
  assign status.out_free     = !m_tvalid || m_tready;

  assign corner = vfc_pkg::tri_corner(vert);
  assign offs   = vfc_pkg::corner_offset(face, corner);
  assign uv     = vfc_pkg::face_uv(face, corner);
  assign pos_x  = {1'b0, cap_x} + {5'b00000, offs[2]};
  assign pos_y  = {1'b0, cap_y} + {5'b00000, offs[1]};
  assign pos_z  = {1'b0, cap_z} + {5'b00000, offs[0]};
  assign id_ext = {{(24 - ID_BITS){1'b0}}, id_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {4'h0, id_ext[vfc_pkg::OUT_ID_BITS-1:0], uv[0], uv[1], pos_z, pos_y, pos_x};
      m_tuser <= face;
      m_tlast <= status.final_vertex;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/voxel_face_cull_mesher.sv @@
// Load items and mesh items of an air voxel produce nothing. Any other mesh item fetches
// the id and tests the six faces, then emits one vertex per cycle unless the output stalls,
// up to 36, stepping over each covered face before the last exposed one (all six when none
// is exposed); the block takes one item at a time.
// Reset clears the controller and the output valid; the voxel store and the neighbor
// planes are not cleared and must be loaded before they are meshed against.
`default_nettype none
module voxel_face_cull_mesher #(
  parameter int SIDE    = 32,
  parameter int ID_BITS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // voxel_x[4:0], voxel_y[9:5], voxel_z[14:10], side[17:15], value[25:18], zero above
  input  wire  [31:0] s_tdata,
  // command[1:0]
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // pos_x[5:0], pos_y[11:6], pos_z[17:12], tex_u[18], tex_v[19], block_id[27:20], zero above
  output logic [31:0] m_tdata,
  // face[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  vfc_pkg::dp_cmd_t    cmd;
  vfc_pkg::dp_status_t status;

  vfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  vfc_datapath #(
    .SIDE    (SIDE),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

@@ verif/voxel_face_cull_mesher_tb.sv @@
module voxel_face_cull_mesher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [vfc_pkg::CMD_BITS-1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [vfc_pkg::SIDE_BITS-1:0] SIDE_MAX_CODE = 3'd7;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 400;

  // Corner offsets as {dx, dy, dz} and texture coordinates as {u, v}, per face and corner.
  localparam logic [2:0] CORNER_OFS [6][4] = '{
    '{3'b011, 3'b111, 3'b110, 3'b010},
    '{3'b000, 3'b100, 3'b101, 3'b001},
    '{3'b100, 3'b110, 3'b111, 3'b101},
    '{3'b001, 3'b011, 3'b010, 3'b000},
    '{3'b001, 3'b101, 3'b111, 3'b011},
    '{3'b010, 3'b110, 3'b100, 3'b000}
  };
  localparam logic [1:0] CORNER_UV [6][4] = '{
    '{2'b00, 2'b10, 2'b11, 2'b01},
    '{2'b01, 2'b11, 2'b10, 2'b00},
    '{2'b01, 2'b00, 2'b10, 2'b11},
    '{2'b01, 2'b00, 2'b10, 2'b11},
    '{2'b01, 2'b11, 2'b10, 2'b00},
    '{2'b00, 2'b10, 2'b11, 2'b01}
  };
  localparam int TRI_CORNER [6] = '{0, 1, 2, 0, 2, 3};
  localparam int STEP_X [6] = '{0, 0, 1, -1, 0, 0};
  localparam int STEP_Y [6] = '{1, -1, 0, 0, 0, 0};
  localparam int STEP_Z [6] = '{0, 0, 0, 0, 1, -1};

  typedef struct {
    logic [vfc_pkg::CMD_BITS-1:0]   cmd;
    logic [vfc_pkg::COORD_BITS-1:0] x;
    logic [vfc_pkg::COORD_BITS-1:0] y;
    logic [vfc_pkg::COORD_BITS-1:0] z;
    logic [vfc_pkg::SIDE_BITS-1:0]  side;
    logic [vfc_pkg::VALUE_BITS-1:0] value;
    bit                             wait_idle;
  } mesh_cmd_t;

  typedef struct {
    logic [vfc_pkg::POS_BITS-1:0]    px;
    logic [vfc_pkg::POS_BITS-1:0]    py;
    logic [vfc_pkg::POS_BITS-1:0]    pz;
    logic                            u;
    logic                            v;
    logic [vfc_pkg::OUT_ID_BITS-1:0] id;
    logic [vfc_pkg::SIDE_BITS-1:0]   face;
    logic                            last;
  } vertex_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  mesh_cmd_t cmd_q[$];
  vertex_t   vertex_q[$];
  logic [14:0] meshable_q[$];

  logic [7:0] chunk_ids [32][32][32];
  bit         plane_empty [6][32][32];
  bit         id_loaded [32][32][32];
  bit         plane_loaded [6][32][32];

  int n_errors = 0;
  int n_accepted = 0;
  int n_vertices = 0;
  int in_pace = 0;
  int out_pace = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  mesh_cmd_t cur_cmd;

  voxel_face_cull_mesher i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic int plane_a(int f, int x, int y, int z);
    return (f < 2) ? x : (f < 4) ? y : x;
  endfunction

  function automatic int plane_b(int f, int x, int y, int z);
    return (f < 4) ? z : y;
  endfunction

  function automatic bit neighbor_inside(int f, int x, int y, int z,
                                         output int nx, output int ny, output int nz);
    nx = x + STEP_X[f];
    ny = y + STEP_Y[f];
    nz = z + STEP_Z[f];
    return nx >= 0 && nx < 32 && ny >= 0 && ny < 32 && nz >= 0 && nz < 32;
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 18;
    endcase
  endfunction

  task automatic apply_command(input mesh_cmd_t c);
    int nx, ny, nz, n;
    bit open;
    logic [2:0] ofs;
    logic [1:0] uv;
    logic [7:0] id;
    vertex_t vx;
    case (c.cmd)
      vfc_pkg::CMD_LOAD_VOXEL: chunk_ids[c.x][c.y][c.z] = c.value;
      vfc_pkg::CMD_LOAD_NEIGHBOR:
        if (c.side < vfc_pkg::NUM_FACES)
          plane_empty[c.side][plane_a(c.side, c.x, c.y, c.z)][plane_b(c.side, c.x, c.y, c.z)] =
            (c.value == 0);
      vfc_pkg::CMD_MESH: begin
        id = chunk_ids[c.x][c.y][c.z];
        n = 0;
        if (id != 0) begin
          for (int f = 0; f < 6; f++) begin
            if (neighbor_inside(f, c.x, c.y, c.z, nx, ny, nz))
              open = (chunk_ids[nx][ny][nz] == 0);
            else
              open = plane_empty[f][plane_a(f, c.x, c.y, c.z)][plane_b(f, c.x, c.y, c.z)];
            if (open) begin
              for (int k = 0; k < 6; k++) begin
                ofs = CORNER_OFS[f][TRI_CORNER[k]];
                uv = CORNER_UV[f][TRI_CORNER[k]];
                vx.px = vfc_pkg::POS_BITS'(c.x) + vfc_pkg::POS_BITS'(ofs[2]);
                vx.py = vfc_pkg::POS_BITS'(c.y) + vfc_pkg::POS_BITS'(ofs[1]);
                vx.pz = vfc_pkg::POS_BITS'(c.z) + vfc_pkg::POS_BITS'(ofs[0]);
                vx.u = uv[1];
                vx.v = uv[0];
                vx.id = id;
                vx.face = vfc_pkg::SIDE_BITS'(f);
                vx.last = 1'b0;
                vertex_q = {vertex_q, vx};
                n++;
              end
            end
          end
          if (n > 0) begin
            vx = vertex_q.pop_back();
            vx.last = 1'b1;
            vertex_q = {vertex_q, vx};
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(logic [vfc_pkg::CMD_BITS-1:0] cmd, int x, int y, int z, int side,
                          int value, bit wait_idle);
    mesh_cmd_t c;
    c.cmd = cmd;
    c.x = vfc_pkg::COORD_BITS'(x);
    c.y = vfc_pkg::COORD_BITS'(y);
    c.z = vfc_pkg::COORD_BITS'(z);
    c.side = vfc_pkg::SIDE_BITS'(side);
    c.value = vfc_pkg::VALUE_BITS'(value);
    c.wait_idle = wait_idle;
    cmd_q = {cmd_q, c};
    if (cmd == vfc_pkg::CMD_LOAD_VOXEL)
      id_loaded[x][y][z] = 1;
    else if (cmd == vfc_pkg::CMD_LOAD_NEIGHBOR && side < 6)
      plane_loaded[side][plane_a(side, x, y, z)][plane_b(side, x, y, z)] = 1;
  endtask

  function automatic int rand_id(int pct_air);
    return ($urandom_range(0, 99) < pct_air) ? 0 : $urandom_range(1, 255);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 31;
      default: return $urandom_range(0, 31);
    endcase
  endfunction

  // Loads a voxel and whatever it is meshed against that is not yet loaded (all of it on
  // refresh); the coordinate along the axis of a boundary plane is ignored by the block, so it gets a random value.
  task automatic prep_voxel(int x, int y, int z, bit refresh);
    int nx, ny, nz, px, py, pz;
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, x, y, z, $urandom_range(0, 7), rand_id(10), 0);
    for (int f = 0; f < 6; f++) begin
      if (neighbor_inside(f, x, y, z, nx, ny, nz)) begin
        if (refresh || !id_loaded[nx][ny][nz])
          push_cmd(vfc_pkg::CMD_LOAD_VOXEL, nx, ny, nz, $urandom_range(0, 7), rand_id(40), 0);
      end else if (refresh || !plane_loaded[f][plane_a(f, x, y, z)][plane_b(f, x, y, z)]) begin
        px = x;
        py = y;
        pz = z;
        if (f < 2) py = $urandom_range(0, 31);
        else if (f < 4) px = $urandom_range(0, 31);
        else pz = $urandom_range(0, 31);
        push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, px, py, pz, f, rand_id(40), 0);
      end
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : driver
    bit offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_command(cur_cmd);
        n_accepted++;
        if (n_accepted % 40 == 0) in_pace = pick_pace();
        gap_left = $urandom_range(0, in_pace);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].wait_idle && vertex_q.size() > 0)) begin
          cur_cmd = cmd_q.pop_front();
          offer = 1'b1;
          s_tdata <= {6'd0, cur_cmd.value, cur_cmd.side, cur_cmd.z, cur_cmd.y, cur_cmd.x};
          s_tuser <= cur_cmd.cmd;
        end
      end
      s_tvalid <= offer;
    end
  end

  always @(posedge clk) begin : monitor
    vertex_t e;
    bit rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex with no expectation: tdata %h tuser %0d", m_tdata, m_tuser);
          n_errors++;
        end else begin
          e = vertex_q.pop_front();
          check_field("pos_x", e.px, m_tdata[5:0]);
          check_field("pos_y", e.py, m_tdata[11:6]);
          check_field("pos_z", e.pz, m_tdata[17:12]);
          check_field("tex_u", e.u, m_tdata[18]);
          check_field("tex_v", e.v, m_tdata[19]);
          check_field("block_id", e.id, m_tdata[27:20]);
          check_field("tdata_pad", 0, m_tdata[31:28]);
          check_field("face", e.face, m_tuser);
          check_field("last", e.last, m_tlast);
        end
        n_vertices++;
        if (n_vertices % 50 == 0) out_pace = pick_pace();
        stall_left = $urandom_range(0, out_pace);
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && n_accepted >= 40 && vertex_q.size() >= 6) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  initial begin
    int base, x, y, z, pick;
    logic [14:0] xyz;

    // Two corner voxels: one with a mix of open and covered faces, one with all six
    // faces open and positions reaching 32.
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 0, 0, 0, vfc_pkg::FACE_POS_Y, 255, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 0, 1, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 0, 17, 0, vfc_pkg::FACE_NEG_Y, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 1, 0, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 31, 0, 0, vfc_pkg::FACE_NEG_X, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 0, 0, 1, 0, 7, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 0, 0, 9, vfc_pkg::FACE_NEG_Z, 200, 0);
    push_cmd(vfc_pkg::CMD_MESH, 0, 0, 0, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 31, 31, 31, SIDE_MAX_CODE, 1, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 31, 0, 31, vfc_pkg::FACE_POS_Y, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 31, 30, 31, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 5, 31, 31, vfc_pkg::FACE_POS_X, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 30, 31, 31, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 31, 31, 0, vfc_pkg::FACE_POS_Z, 0, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 31, 31, 30, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_MESH, 31, 31, 31, 0, 0, 1);
    // Items the block must ignore; the mesh after them must be unchanged.
    push_cmd(CMD_UNUSED, 31, 31, 31, SIDE_MAX_CODE, 255, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 31, 31, 31, vfc_pkg::NUM_FACES, 255, 0);
    push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, 31, 0, 31, SIDE_MAX_CODE, 255, 0);
    push_cmd(vfc_pkg::CMD_MESH, 31, 31, 31, SIDE_MAX_CODE, 255, 0);
    push_cmd(vfc_pkg::CMD_LOAD_VOXEL, 31, 31, 31, 0, 0, 0);
    push_cmd(vfc_pkg::CMD_MESH, 31, 31, 31, 0, 0, 0);
    meshable_q = {meshable_q, 15'd0};
    meshable_q = {meshable_q, {5'd31, 5'd31, 5'd31}};

    base = cmd_q.size();
    while (cmd_q.size() < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        prep_voxel(x, y, z, $urandom_range(0, 1));
        push_cmd(vfc_pkg::CMD_MESH, x, y, z, $urandom_range(0, 7), $urandom_range(0, 255),
                 $urandom_range(0, 19) == 0);
        meshable_q = {meshable_q, {5'(x), 5'(y), 5'(z)}};
      end else if (pick < 8) begin
        xyz = meshable_q[$urandom_range(0, meshable_q.size() - 1)];
        push_cmd(vfc_pkg::CMD_MESH, xyz[14:10], xyz[9:5], xyz[4:0], $urandom_range(0, 7),
                 $urandom_range(0, 255), 0);
      end else begin
        case ($urandom_range(0, 3))
          0: push_cmd(CMD_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 255), 0);
          1: push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(6, 7), $urandom_range(0, 255), 0);
          2: push_cmd(vfc_pkg::CMD_LOAD_VOXEL, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 7), rand_id(40), 0);
          default: push_cmd(vfc_pkg::CMD_LOAD_NEIGHBOR, $urandom_range(0, 31),
                            $urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom_range(0, 5), rand_id(40), 0);
        endcase
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (cmd_q.size() > 0 || s_tvalid || vertex_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (n_errors == 0)
      $display("[voxel_face_cull_mesher] OK");
    else
      $display("[voxel_face_cull_mesher] ERROR");
    $finish;
  end

  initial begin
    #10ms;
    $display("[voxel_face_cull_mesher] ERROR");
    $finish;
  end

endmodule
